@@ rtl/core/cfws_pkg.sv @@
// Package for the character queue with search: operation and status codes,
// result layout, sequencer states and the result packing helper.
// No dependencies; imported by char_fifo_with_search_top.
`default_nettype none

package cfws_pkg;

  // Operation codes carried in the slave-side tuser
  typedef enum logic [2:0] {
    FN_PUSH      = 3'd0,
    FN_POP       = 3'd1,
    FN_SEARCH    = 3'd2,
    FN_PEEK_HEAD = 3'd3,
    FN_PEEK_TAIL = 3'd4,
    FN_CLEAR     = 3'd5
  } func_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_NONE  = 2'd2,
    STAT_FULL  = 2'd3
  } status_e;

  // Fixed field widths
  localparam int unsigned CharW  = 8;
  localparam int unsigned FuncW  = 3;
  localparam int unsigned PosW   = 5;
  localparam int unsigned EarlW  = 4;
  localparam int unsigned ResW   = 24;

  // Result word, lowest field in the lowest bits
  typedef struct packed {
    logic [4:0]       pad;
    logic [EarlW-1:0] earlier_matches;
    logic [PosW-1:0]  position;
    logic [CharW-1:0] char_out;
    logic [1:0]       status;
  } res_t;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_FINAL = 4'b1000
  } state_e;

  function automatic res_t make_res(status_e st, logic [CharW-1:0] ch,
                                    logic [PosW-1:0] pos, logic [EarlW-1:0] earl);
    res_t r;
    r.pad             = '0;
    r.earlier_matches = earl;
    r.position        = pos;
    r.char_out        = ch;
    r.status          = st;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/cfws_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the character ring.
`default_nettype none

module cfws_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/core/char_fifo_with_search_top.sv @@
// Character queue with search. Push, clear, and every operation on an empty
// queue answer straight from the idle state; pop and peeks first do one ring read.
// Search uses the single RAM read port to visit one queued entry per cycle
// while the output does not stall; a new operation is taken only when idle.
// Reset (rst_ni low, asynchronous) empties the queue and zeroes the head;
// ring contents are not cleared, and no clearing pass is needed.
`default_nettype none

module char_fifo_with_search_top #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Slave side
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_in
  input  wire logic [2:0]  s_axis_tuser,   // [2:0] func
  // Master side
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [1:0] status, [9:2] char_out,
                                           // [14:10] position,
                                           // [18:15] earlier_matches, rest 0
  output logic             m_axis_tlast    // last result of the transaction
);

  import cfws_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DepthA = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  // Add an offset to a ring index and wrap at DEPTH
  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off[AW-1:0]};
    if (s >= DepthA) begin
      s = s - DepthA;
    end
    return s[AW-1:0];
  endfunction

  state_e           state_q, state_d;
  logic [AW-1:0]    head_q, head_d;
  logic [CW-1:0]    count_q, count_d;
  logic [AW-1:0]    rd_addr_q, rd_addr_d;
  logic [CW-1:0]    scan_i_q, scan_i_d;
  logic [EarlW-1:0] match_n_q, match_n_d;
  logic [CharW-1:0] key_q, key_d;
  logic             pend_v_q, pend_v_d;
  logic [PosW-1:0]  pend_pos_q, pend_pos_d;
  logic [EarlW-1:0] pend_earl_q, pend_earl_d;
  logic             out_valid_q, out_valid_d;
  res_t             out_q, out_d;
  logic             out_last_q, out_last_d;

  logic             we;
  logic [CharW-1:0] rdata;
  logic             out_free;
  logic             in_acc;
  logic [FuncW-1:0] func;
  logic             empty;
  logic             full;
  logic             hit;
  logic             stall;
  logic [CW:0]      scan_next;

  assign func      = s_axis_tuser;
  assign out_free  = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign empty     = (count_q == '0);
  assign full      = (count_q == DepthC);
  assign hit       = (rdata == key_q);
  assign stall     = hit && pend_v_q && !out_free;
  assign scan_next = {1'b0, scan_i_q} + (CW + 1)'(1);

  // Character ring
  cfws_ram #(
    .WIDTH (CharW),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wrap_add(head_q, count_q)),
    .wdata_i (s_axis_tdata),
    .raddr_i (rd_addr_d),
    .rdata_o (rdata)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    rd_addr_d   = rd_addr_q;
    scan_i_d    = scan_i_q;
    match_n_d   = match_n_q;
    key_d       = key_q;
    pend_v_d    = pend_v_q;
    pend_pos_d  = pend_pos_q;
    pend_earl_d = pend_earl_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_d       = out_q;
    out_last_d  = out_last_q;
    we          = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (func)
            FN_PUSH: begin
              out_valid_d = 1'b1;
              out_last_d  = 1'b1;
              if (full) begin
                out_d = make_res(STAT_FULL, '0, '0, '0);
              end else begin
                we      = 1'b1;
                count_d = count_q + CW'(1);
                out_d   = make_res(STAT_OK, '0, '0, '0);
              end
            end
            FN_POP, FN_SEARCH, FN_PEEK_HEAD, FN_PEEK_TAIL, FN_CLEAR: begin
              if (empty) begin
                out_valid_d = 1'b1;
                out_last_d  = 1'b1;
                out_d       = make_res(STAT_EMPTY, '0, '0, '0);
              end else begin
                unique case (func)
                  FN_POP: begin
                    rd_addr_d = head_q;
                    head_d    = wrap_add(head_q, CW'(1));
                    count_d   = count_q - CW'(1);
                    state_d   = ST_READ;
                  end
                  FN_PEEK_HEAD: begin
                    rd_addr_d = head_q;
                    state_d   = ST_READ;
                  end
                  FN_PEEK_TAIL: begin
                    rd_addr_d = wrap_add(head_q, count_q - CW'(1));
                    state_d   = ST_READ;
                  end
                  FN_SEARCH: begin
                    rd_addr_d = head_q;
                    scan_i_d  = '0;
                    match_n_d = '0;
                    pend_v_d  = 1'b0;
                    key_d     = s_axis_tdata;
                    state_d   = ST_SCAN;
                  end
                  default: begin
                    // clear
                    count_d     = '0;
                    head_d      = '0;
                    out_valid_d = 1'b1;
                    out_last_d  = 1'b1;
                    out_d       = make_res(STAT_OK, '0, '0, '0);
                  end
                endcase
              end
            end
            default: ;  // unused codes: drop
          endcase
        end
      end

      ST_READ: begin
        // Hand out the popped or peeked character
        if (out_free) begin
          out_valid_d = 1'b1;
          out_last_d  = 1'b1;
          out_d       = make_res(STAT_OK, rdata, '0, '0);
          state_d     = ST_IDLE;
        end
      end

      ST_SCAN: begin
        // Compare one entry per cycle unless the output stalls; hold one match back to mark the last
        if (!stall) begin
          if (hit) begin
            if (pend_v_q) begin
              out_valid_d = 1'b1;
              out_last_d  = 1'b0;
              out_d       = make_res(STAT_OK, key_q, pend_pos_q, pend_earl_q);
            end
            pend_v_d    = 1'b1;
            pend_pos_d  = PosW'(scan_next);
            pend_earl_d = match_n_q;
            match_n_d   = match_n_q + EarlW'(1);
          end
          scan_i_d  = scan_next[CW-1:0];
          rd_addr_d = wrap_add(rd_addr_q, CW'(1));
          if ((hit && (match_n_q == {EarlW{1'b1}})) ||
              (scan_next == {1'b0, count_q})) begin
            state_d = ST_FINAL;
          end
        end
      end

      ST_FINAL: begin
        // Emit the held match as last, or report no match
        if (out_free) begin
          out_valid_d = 1'b1;
          out_last_d  = 1'b1;
          if (pend_v_q) begin
            out_d = make_res(STAT_OK, key_q, pend_pos_q, pend_earl_q);
          end else begin
            out_d = make_res(STAT_NONE, '0, '0, '0);
          end
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      pend_v_q    <= 1'b0;
      match_n_q   <= '0;
      scan_i_q    <= '0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      pend_v_q    <= pend_v_d;
      match_n_q   <= match_n_d;
      scan_i_q    <= scan_i_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rd_addr_q   <= rd_addr_d;
    key_q       <= key_d;
    pend_pos_q  <= pend_pos_d;
    pend_earl_q <= pend_earl_d;
    out_q       <= out_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tlast  = out_last_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("entry count exceeds ring depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (func == FN_PUSH) && !full) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("accepted push did not grow the queue");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (scan_i_q < count_q))
    else $error("search index beyond queued entries");

  a_match_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |=>
      ((match_n_q == $past(match_n_q)) || (match_n_q == $past(match_n_q) + EarlW'(1))))
    else $error("match count moved by more than one");

  a_final_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FINAL) && out_free) |=> (m_axis_tvalid && m_axis_tlast))
    else $error("search end did not deliver a last result");

endmodule

`default_nettype wire
